>>> src/pts_pkg.sv
`timescale 1ns / 1ps

package pts_pkg;

	localparam int RING_DEPTH_DEF       = 16;
	localparam int NUM_SOURCES_DEF      = 4;
	localparam int LINE_OFFSET_BITS_DEF = 6;

	localparam int ADDR_W   = 64;
	localparam int COUNT_W  = 16;
	localparam int FILL_W   = 2;
	localparam int ID_W     = 2;
	localparam int ACTIVE_W = 3;

	localparam int S_TDATA_W = 136;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 152;
	localparam int M_TUSER_W = 2;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_LENGTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_OFF_THRESHOLD = 1'b1;

	localparam logic [COUNT_W-1:0] PHASE_LENGTH_RST  = 16'd2048;
	localparam logic [COUNT_W-1:0] OFF_THRESHOLD_RST = 16'd0;
	localparam logic [COUNT_W-1:0] COUNT_MAX         = 16'hFFFF;

	localparam logic CMD_CANDIDATE = 1'b0;
	localparam logic CMD_DEMAND    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EVAL  = 3'b010,
		ST_CLOSE = 3'b100
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic close;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic close_req;
	} dp_status_t;

endpackage

>>> src/pts_ctrl.sv
`timescale 1ns / 1ps

module pts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  pts_pkg::dp_status_t status,
	output pts_pkg::ctrl_cmd_t  cmd
);

	pts_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == pts_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		unique case (state_q)
			pts_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = pts_pkg::ST_EVAL;
				end
			end
			pts_pkg::ST_EVAL: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					if (status.close_req) begin
						state_d = pts_pkg::ST_CLOSE;
					end else begin
						cmd.load = 1'b1;
						state_d  = pts_pkg::ST_IDLE;
					end
				end
			end
			pts_pkg::ST_CLOSE: begin
				if (out_free) begin
					cmd.close = 1'b1;
					cmd.load  = 1'b1;
					state_d   = pts_pkg::ST_IDLE;
				end
			end
			default: state_d = pts_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pts_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/pts_datapath.sv
`timescale 1ns / 1ps

module pts_datapath #(
	parameter int RING_DEPTH       = pts_pkg::RING_DEPTH_DEF,
	parameter int NUM_SOURCES      = pts_pkg::NUM_SOURCES_DEF,
	parameter int LINE_OFFSET_BITS = pts_pkg::LINE_OFFSET_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [pts_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [pts_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic [pts_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [pts_pkg::M_TUSER_W-1:0]   m_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pts_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  pts_pkg::ctrl_cmd_t              cmd,
	output pts_pkg::dp_status_t             status
);

	localparam int LINE_W = pts_pkg::ADDR_W - LINE_OFFSET_BITS;
	localparam int PTR_W  = $clog2(RING_DEPTH);
	localparam int SRC_W  = $clog2(NUM_SOURCES);
	localparam int SEL_W  = $clog2(NUM_SOURCES + 1);
	localparam int AW     = pts_pkg::ADDR_W;
	localparam int CW     = pts_pkg::COUNT_W;
	localparam int FW     = pts_pkg::FILL_W;
	localparam int PAD_W  = pts_pkg::M_TDATA_W - 2 * AW - FW - pts_pkg::ACTIVE_W - CW;

	logic [LINE_W-1:0] ring_q [NUM_SOURCES][RING_DEPTH];
	logic [PTR_W-1:0]  ptr_q  [NUM_SOURCES];
	logic [CW-1:0]     cnt_q  [NUM_SOURCES];
	logic [CW-1:0]     phase_q;
	logic [CW-1:0]     phase_len_q;
	logic [CW-1:0]     thr_q;
	logic [SEL_W-1:0]  sel_q;

	logic                    cmd_s1;
	logic [pts_pkg::ID_W-1:0] id_s1;
	logic [AW-1:0]           target_s1;
	logic [AW-1:0]           base_s1;
	logic [FW-1:0]           fill_s1;
	logic [NUM_SOURCES-1:0]  hit_s1;

	logic [LINE_W-1:0]            in_line;
	logic [NUM_SOURCES-1:0]       hit_d;
	logic [LINE_W-1:0]            line_s1;
	logic                         src_ok;
	logic [SRC_W-1:0]             src_idx;
	logic [CW-1:0]                phase_next;
	logic [CW-1:0]                best_cnt;
	logic [SRC_W-1:0]             best_idx;
	logic [SEL_W-1:0]             sel_new;
	logic [pts_pkg::ACTIVE_W-1:0] act_cur;
	logic [pts_pkg::ACTIVE_W-1:0] act_new;
	logic                         issue_d;

	logic                         issue_q;
	logic                         phase_end_q;
	logic [AW-1:0]                o_target_q;
	logic [AW-1:0]                o_base_q;
	logic [FW-1:0]                o_fill_q;
	logic [pts_pkg::ACTIVE_W-1:0] o_active_q;
	logic [CW-1:0]                o_best_q;

	assign cfg_ready = 1'b1;
	assign in_line   = s_tdata[AW-1:LINE_OFFSET_BITS];
	assign line_s1   = target_s1[AW-1:LINE_OFFSET_BITS];
	assign src_ok    = (int'(id_s1) < NUM_SOURCES);
	assign src_idx   = SRC_W'(id_s1);
	assign phase_next = phase_q + 16'd1;
	assign status.close_req = (cmd_s1 == pts_pkg::CMD_DEMAND) && (phase_next >= phase_len_q);
	assign issue_d = (cmd_s1 == pts_pkg::CMD_CANDIDATE) && src_ok
		&& (int'(sel_q) == int'(id_s1));

	always_comb begin
		for (int s = 0; s < NUM_SOURCES; s++) begin
			hit_d[s] = 1'b0;
			for (int k = 0; k < RING_DEPTH; k++) begin
				hit_d[s] = hit_d[s] | (ring_q[s][k] == in_line);
			end
		end
	end

	always_comb begin
		best_cnt = '0;
		best_idx = '0;
		for (int i = 0; i < NUM_SOURCES; i++) begin
			if (cnt_q[i] > best_cnt) begin
				best_cnt = cnt_q[i];
				best_idx = SRC_W'(i);
			end
		end
	end

	assign sel_new = (best_cnt > thr_q) ? SEL_W'(best_idx) : SEL_W'(NUM_SOURCES);
	assign act_cur = (int'(sel_q) >= NUM_SOURCES) ? pts_pkg::ACTIVE_W'(NUM_SOURCES)
		: pts_pkg::ACTIVE_W'(sel_q);
	assign act_new = (int'(sel_new) >= NUM_SOURCES) ? pts_pkg::ACTIVE_W'(NUM_SOURCES)
		: pts_pkg::ACTIVE_W'(sel_new);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_s1    <= s_tuser[0];
			id_s1     <= s_tuser[pts_pkg::ID_W:1];
			target_s1 <= s_tdata[AW-1:0];
			base_s1   <= s_tdata[2*AW-1:AW];
			fill_s1   <= s_tdata[2*AW+FW-1:2*AW];
			hit_s1    <= hit_d;
		end
		if (cmd.load) begin
			if (cmd.close) begin
				issue_q     <= 1'b0;
				phase_end_q <= 1'b1;
				o_target_q  <= '0;
				o_base_q    <= '0;
				o_fill_q    <= '0;
				o_active_q  <= act_new;
				o_best_q    <= best_cnt;
			end else begin
				issue_q     <= issue_d;
				phase_end_q <= 1'b0;
				o_target_q  <= issue_d ? target_s1 : '0;
				o_base_q    <= issue_d ? base_s1 : '0;
				o_fill_q    <= issue_d ? fill_s1 : '0;
				o_active_q  <= act_cur;
				o_best_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SOURCES; s++) begin
				ptr_q[s] <= '0;
				cnt_q[s] <= '0;
				for (int k = 0; k < RING_DEPTH; k++) begin
					ring_q[s][k] <= '0;
				end
			end
			phase_q     <= '0;
			phase_len_q <= pts_pkg::PHASE_LENGTH_RST;
			thr_q       <= pts_pkg::OFF_THRESHOLD_RST;
			sel_q       <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					pts_pkg::REG_PHASE_LENGTH:  phase_len_q <= cfg_data;
					pts_pkg::REG_OFF_THRESHOLD: thr_q       <= cfg_data;
				endcase
			end
			if (cmd.exec) begin
				if (cmd_s1 == pts_pkg::CMD_CANDIDATE) begin
					if (src_ok) begin
						for (int s = 0; s < NUM_SOURCES; s++) begin
							if (src_idx == SRC_W'(s)) begin
								for (int k = 0; k < RING_DEPTH; k++) begin
									if (ptr_q[s] == PTR_W'(k)) begin
										ring_q[s][k] <= line_s1;
									end
								end
								ptr_q[s] <= (ptr_q[s] == PTR_W'(RING_DEPTH - 1)) ? '0
									: ptr_q[s] + PTR_W'(1);
							end
						end
					end
				end else begin
					for (int s = 0; s < NUM_SOURCES; s++) begin
						if (hit_s1[s] && (cnt_q[s] != pts_pkg::COUNT_MAX)) begin
							cnt_q[s] <= cnt_q[s] + 16'd1;
						end
					end
					phase_q <= status.close_req ? '0 : phase_next;
				end
			end
			if (cmd.close) begin
				for (int s = 0; s < NUM_SOURCES; s++) begin
					cnt_q[s] <= '0;
				end
				sel_q <= sel_new;
			end
		end
	end

	assign m_tdata = {{PAD_W{1'b0}}, o_best_q, o_active_q, o_fill_q, o_base_q, o_target_q};
	assign m_tuser = {phase_end_q, issue_q};

endmodule

>>> src/prefetcher_tournament_selector.sv
`timescale 1ns / 1ps

// Tournament selection between candidate prefetchers. Each item gives exactly
// one result. A candidate, or a demand access that does not close a learning
// phase, passes a compare step, which checks the demand line against every ring
// entry in parallel and registers the per-source match, and an update step for
// the rings, hit counters and phase count. A demand that closes a phase adds a
// close step for the arg-max over the hit counters and the threshold check.
// Items are taken one at a time; the result sits in an output register, so a
// new request is taken while the previous result waits on m_tready.
// Configuration writes are accepted in every cycle and take effect at once.

module prefetcher_tournament_selector #(
	parameter int RING_DEPTH       = pts_pkg::RING_DEPTH_DEF,
	parameter int NUM_SOURCES      = pts_pkg::NUM_SOURCES_DEF,
	parameter int LINE_OFFSET_BITS = pts_pkg::LINE_OFFSET_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// target_address[63:0], base_address[127:64], cache_level[129:128]
	input  logic [pts_pkg::S_TDATA_W-1:0]   s_tdata,
	// command[0], prefetcher_id[2:1]
	input  logic [pts_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// issue_target_address[63:0], issue_base_address[127:64],
	// issue_cache_level[129:128], active_prefetcher[132:130],
	// phase_best_hits[148:133]
	output logic [pts_pkg::M_TDATA_W-1:0]   m_tdata,
	// issue[0], phase_end[1]
	output logic [pts_pkg::M_TUSER_W-1:0]   m_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pts_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data
);

	pts_pkg::ctrl_cmd_t  cmd;
	pts_pkg::dp_status_t status;

	pts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pts_datapath #(
		.RING_DEPTH       (RING_DEPTH),
		.NUM_SOURCES      (NUM_SOURCES),
		.LINE_OFFSET_BITS (LINE_OFFSET_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

>>> src/pts_checker.sv
`timescale 1ns / 1ps

module pts_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pts_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [pts_pkg::M_TUSER_W-1:0] m_tuser
);

	localparam int BEST_LO = 2 * pts_pkg::ADDR_W + pts_pkg::FILL_W + pts_pkg::ACTIVE_W;
	localparam int ISSUE_HI = 2 * pts_pkg::ADDR_W + pts_pkg::FILL_W - 1;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken during evaluation");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tuser[1])
		else $error("issue and phase end together");

	a_best: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata[BEST_LO+pts_pkg::COUNT_W-1:BEST_LO] == '0)
		else $error("best count outside phase end");

	a_noissue: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[ISSUE_HI:0] == '0)
		else $error("prefetch fields set without issue");

endmodule

bind prefetcher_tournament_selector pts_checker u_pts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
